@@ sv/jmsc_pkg.sv @@
// ----------------------------------------------------------------------------
// jmsc_pkg
// Shared types and constants of the JPEG marker structure checker.
// ----------------------------------------------------------------------------
package jmsc_pkg;

  typedef enum logic [7:0] {
    PH_SOI0      = 8'b0000_0001,
    PH_SOI1      = 8'b0000_0010,
    PH_EXPECT_FF = 8'b0000_0100,
    PH_FILL      = 8'b0000_1000,
    PH_LEN_HI    = 8'b0001_0000,
    PH_LEN_LO    = 8'b0010_0000,
    PH_PAYLOAD   = 8'b0100_0000,
    PH_ENTROPY   = 8'b1000_0000
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_INVALID  = 3'd1,
    ST_RESOURCE = 3'd2,
    ST_DIMS     = 3'd3,
    ST_PROFILE  = 3'd4
  } status_t;

  localparam logic [1:0] REG_RECORD    = 2'd0;
  localparam logic [1:0] REG_DIMENSION = 2'd1;
  localparam logic [1:0] REG_PIXEL     = 2'd2;
  localparam logic [1:0] REG_COMPONENT = 2'd3;

  localparam logic [7:0] M_SOI = 8'hd8;
  localparam logic [7:0] M_EOI = 8'hd9;
  localparam logic [7:0] M_SOS = 8'hda;
  localparam logic [7:0] M_DHT = 8'hc4;
  localparam logic [7:0] M_JPG = 8'hc8;
  localparam logic [7:0] M_DAC = 8'hcc;
  localparam logic [7:0] M_SOF0 = 8'hc0;
  localparam logic [7:0] M_SOF1 = 8'hc1;
  localparam logic [7:0] M_SOF2 = 8'hc2;
  localparam logic [7:0] SAMP_11 = 8'h11;
  localparam logic [7:0] SAMP_21 = 8'h21;
  localparam logic [7:0] SAMP_22 = 8'h22;

  localparam logic [15:0] RECORD_LIMIT_RST    = 16'd16384;
  localparam logic [15:0] DIMENSION_LIMIT_RST = 16'd16384;
  localparam logic [31:0] PIXEL_LIMIT_RST     = 32'd67108864;
  localparam logic [7:0]  COMPONENT_LIMIT_RST = 8'd10;

  typedef struct packed {
    logic [15:0] width;
    logic [15:0] height;
    logic [7:0]  comps;
    logic [7:0]  precision;
    logic [7:0]  kind;
  } frame_t;

  typedef struct packed {
    logic [15:0] record_limit;
    logic [15:0] dimension_limit;
    logic [31:0] pixel_limit;
    logic [7:0]  component_limit;
  } cfg_t;

  function automatic logic is_frame_marker(input logic [7:0] m);
    return (m[7:4] == 4'hc) && (m != M_DHT) && (m != M_JPG) && (m != M_DAC);
  endfunction

  function automatic logic is_restart(input logic [7:0] m);
    return m[7:3] == 5'b11010;
  endfunction

endpackage

@@ sv/jmsc_parser.sv @@
// ----------------------------------------------------------------------------
// jmsc_parser
// Byte-wise marker parser: one byte per cycle while step is high, latches the first error, and
// on the last byte presents the parse state for the verdict stage.
// ----------------------------------------------------------------------------
module jmsc_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          byte_value,
  input  logic                last_byte,
  input  logic [15:0]         record_limit,
  output jmsc_pkg::status_t   err_o,
  output logic                end_seen_o,
  output logic                frame_seen_o,
  output logic                unsup_o,
  output jmsc_pkg::frame_t    frame_o
);

  jmsc_pkg::phase_t  phase_r, phase_nxt;
  jmsc_pkg::status_t err_r, err_nxt;
  logic        entropy_r, entropy_nxt;
  logic        frame_seen_r, frame_seen_nxt;
  logic        scan_seen_r, scan_seen_nxt;
  logic        end_seen_r, end_seen_nxt;
  logic        unsup_r, unsup_nxt;
  logic [15:0] rec_r, rec_nxt;
  logic [7:0]  marker_r, marker_nxt;
  logic [15:0] remain_r, remain_nxt;
  logic [15:0] pos_r, pos_nxt;
  jmsc_pkg::frame_t frame_r, frame_nxt;
  logic [23:0] comp_r [3];
  logic [23:0] comp_nxt [3];
  logic [1:0]  sub_r, sub_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [255:0] id_map_r, id_map_nxt;

  logic        active;
  logic        is_fm;
  logic [15:0] len;
  logic [15:0] remain_dec;
  logic [17:0] need;
  logic [7:0]  b;
  logic [7:0]  id0, s0, t0, id1, s1, id2, s2;
  logic        unsup_f;

  assign b      = byte_value;
  assign active = (err_r == jmsc_pkg::ST_OK) && !end_seen_r;
  assign is_fm  = jmsc_pkg::is_frame_marker(marker_r);
  assign len    = {remain_r[7:0], b};
  assign remain_dec = remain_r - 16'd1;
  assign need   = 18'd6 + {b, 1'b0} + {10'd0, b};

  assign id0 = comp_r[0][23:16];
  assign s0  = comp_r[0][15:8];
  // single-component frame: its table byte is the one closing the segment
  assign t0  = (idx_r == 2'd0 && sub_r == 2'd2) ? b : comp_r[0][7:0];
  assign id1 = comp_r[1][23:16];
  assign s1  = comp_r[1][15:8];
  assign id2 = comp_r[2][23:16];
  assign s2  = comp_r[2][15:8];

  always_comb begin
    unsup_f = unsup_r;
    if (frame_r.kind != jmsc_pkg::M_SOF0 && frame_r.kind != jmsc_pkg::M_SOF2) begin
      unsup_f = 1'b1;
    end
    if (frame_r.precision != 8'd8 || (frame_r.comps != 8'd1 && frame_r.comps != 8'd3)) begin
      unsup_f = 1'b1;
    end else if (frame_r.comps == 8'd1) begin
      if (id0 != 8'd1 || s0 != jmsc_pkg::SAMP_11 || t0 != 8'd0) unsup_f = 1'b1;
    end else if (id0 != 8'd1 || id1 != 8'd2 || id2 != 8'd3 ||
                 (s0 != jmsc_pkg::SAMP_11 && s0 != jmsc_pkg::SAMP_21 &&
                  s0 != jmsc_pkg::SAMP_22) ||
                 s1 != jmsc_pkg::SAMP_11 || s2 != jmsc_pkg::SAMP_11) begin
      unsup_f = 1'b1;
    end
  end

  always_comb begin
    logic do_marker;
    phase_nxt      = phase_r;
    err_nxt        = err_r;
    entropy_nxt    = entropy_r;
    frame_seen_nxt = frame_seen_r;
    scan_seen_nxt  = scan_seen_r;
    end_seen_nxt   = end_seen_r;
    unsup_nxt      = unsup_r;
    rec_nxt        = rec_r;
    marker_nxt     = marker_r;
    remain_nxt     = remain_r;
    pos_nxt        = pos_r;
    frame_nxt      = frame_r;
    comp_nxt       = comp_r;
    sub_nxt        = sub_r;
    idx_nxt        = idx_r;
    id_map_nxt     = id_map_r;
    do_marker      = 1'b0;
    if (active) begin
      case (phase_r)
        jmsc_pkg::PH_SOI0: begin
          if (b != 8'hff) err_nxt = jmsc_pkg::ST_INVALID;
          else phase_nxt = jmsc_pkg::PH_SOI1;
        end
        jmsc_pkg::PH_SOI1: begin
          if (b != jmsc_pkg::M_SOI) err_nxt = jmsc_pkg::ST_INVALID;
          else phase_nxt = jmsc_pkg::PH_EXPECT_FF;
        end
        jmsc_pkg::PH_EXPECT_FF: begin
          if (b != 8'hff) err_nxt = jmsc_pkg::ST_INVALID;
          else phase_nxt = jmsc_pkg::PH_FILL;
        end
        jmsc_pkg::PH_FILL: begin
          if (b != 8'hff) begin
            if (entropy_r && b == 8'h00) begin
              phase_nxt = jmsc_pkg::PH_ENTROPY;
            end else if (entropy_r && jmsc_pkg::is_restart(b)) begin
              if (rec_r >= record_limit) err_nxt = jmsc_pkg::ST_RESOURCE;
              else begin
                rec_nxt   = rec_r + 16'd1;
                phase_nxt = jmsc_pkg::PH_ENTROPY;
              end
            end else begin
              entropy_nxt = 1'b0;
              do_marker   = 1'b1;
            end
          end
        end
        jmsc_pkg::PH_LEN_HI: begin
          remain_nxt = {8'd0, b};
          phase_nxt  = jmsc_pkg::PH_LEN_LO;
        end
        jmsc_pkg::PH_LEN_LO: begin
          if (len < 16'd2) err_nxt = jmsc_pkg::ST_INVALID;
          else if (is_fm && (frame_seen_r || len < 16'd8)) err_nxt = jmsc_pkg::ST_INVALID;
          else if (marker_r == jmsc_pkg::M_SOS && (!frame_seen_r || len < 16'd6))
            err_nxt = jmsc_pkg::ST_INVALID;
          else begin
            if (marker_r == jmsc_pkg::M_SOS) scan_seen_nxt = 1'b1;
            remain_nxt = len - 16'd2;
            pos_nxt    = 16'd0;
            sub_nxt    = 2'd0;
            idx_nxt    = 2'd0;
            phase_nxt  = (len == 16'd2) ? jmsc_pkg::PH_EXPECT_FF : jmsc_pkg::PH_PAYLOAD;
          end
        end
        jmsc_pkg::PH_PAYLOAD: begin
          logic ferr;
          ferr = 1'b0;
          if (is_fm) begin
            case (pos_r)
              16'd0: frame_nxt.precision = b;
              16'd1: frame_nxt.height[15:8] = b;
              16'd2: frame_nxt.height[7:0] = b;
              16'd3: frame_nxt.width[15:8] = b;
              16'd4: frame_nxt.width[7:0] = b;
              16'd5: begin
                frame_nxt.comps = b;
                if ({2'd0, pos_r} + {2'd0, remain_r} != need) begin
                  ferr = 1'b1;
                end else begin
                  frame_seen_nxt = 1'b1;
                  frame_nxt.kind = marker_r;
                  if (b == 8'd0 || frame_r.precision == 8'd0) ferr = 1'b1;
                end
              end
              default: begin
                if (sub_r == 2'd0) begin
                  if (id_map_r[b]) ferr = 1'b1;
                  else id_map_nxt[b] = 1'b1;
                end else if (sub_r == 2'd1) begin
                  if (b[7:4] == 4'd0 || b[3:0] == 4'd0 || b[7:4] > 4'd4 || b[3:0] > 4'd4)
                    ferr = 1'b1;
                end else if (b > 8'd3) begin
                  ferr = 1'b1;
                end
                if (!ferr && idx_r != 2'd3) begin
                  case (sub_r)
                    2'd0:    comp_nxt[idx_r][23:16] = b;
                    2'd1:    comp_nxt[idx_r][15:8]  = b;
                    default: comp_nxt[idx_r][7:0]   = b;
                  endcase
                end
                if (sub_r == 2'd2) begin
                  sub_nxt = 2'd0;
                  if (idx_r != 2'd3) idx_nxt = idx_r + 2'd1;
                end else begin
                  sub_nxt = sub_r + 2'd1;
                end
              end
            endcase
          end
          if (ferr) begin
            err_nxt = jmsc_pkg::ST_INVALID;
          end else begin
            pos_nxt    = pos_r + 16'd1;
            remain_nxt = remain_dec;
            if (remain_dec == 16'd0) begin
              if (is_fm) begin
                unsup_nxt = unsup_f;
                phase_nxt = jmsc_pkg::PH_EXPECT_FF;
              end else if (marker_r == jmsc_pkg::M_SOS) begin
                entropy_nxt = 1'b1;
                phase_nxt   = jmsc_pkg::PH_ENTROPY;
              end else begin
                phase_nxt = jmsc_pkg::PH_EXPECT_FF;
              end
            end
          end
        end
        jmsc_pkg::PH_ENTROPY: begin
          if (b == 8'hff) phase_nxt = jmsc_pkg::PH_FILL;
        end
        default: err_nxt = jmsc_pkg::ST_INVALID;
      endcase
      if (do_marker) begin
        if (rec_r >= record_limit) begin
          err_nxt = jmsc_pkg::ST_RESOURCE;
        end else begin
          rec_nxt    = rec_r + 16'd1;
          marker_nxt = b;
          if (b == jmsc_pkg::M_EOI) begin
            if (!frame_seen_r || !scan_seen_r || !last_byte) err_nxt = jmsc_pkg::ST_INVALID;
            else end_seen_nxt = 1'b1;
          end else if (b == jmsc_pkg::M_SOI || b == 8'h00 || b == 8'h01 ||
                       jmsc_pkg::is_restart(b)) begin
            err_nxt = jmsc_pkg::ST_INVALID;
          end else begin
            phase_nxt = jmsc_pkg::PH_LEN_HI;
          end
        end
      end
    end
  end

  // Verdict taps the updated state of the last byte.
  assign err_o        = err_nxt;
  assign end_seen_o   = end_seen_nxt;
  assign frame_seen_o = frame_seen_nxt;
  assign unsup_o      = unsup_nxt;
  assign frame_o      = frame_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_byte)) begin
      phase_r      <= jmsc_pkg::PH_SOI0;
      err_r        <= jmsc_pkg::ST_OK;
      entropy_r    <= 1'b0;
      frame_seen_r <= 1'b0;
      scan_seen_r  <= 1'b0;
      end_seen_r   <= 1'b0;
      unsup_r      <= 1'b0;
      rec_r        <= 16'd1;
      marker_r     <= 8'd0;
      remain_r     <= 16'd0;
      pos_r        <= 16'd0;
      frame_r      <= '0;
      comp_r       <= '{default: 24'd0};
      sub_r        <= 2'd0;
      idx_r        <= 2'd0;
      id_map_r     <= '0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      err_r        <= err_nxt;
      entropy_r    <= entropy_nxt;
      frame_seen_r <= frame_seen_nxt;
      scan_seen_r  <= scan_seen_nxt;
      end_seen_r   <= end_seen_nxt;
      unsup_r      <= unsup_nxt;
      rec_r        <= rec_nxt;
      marker_r     <= marker_nxt;
      remain_r     <= remain_nxt;
      pos_r        <= pos_nxt;
      frame_r      <= frame_nxt;
      comp_r       <= comp_nxt;
      sub_r        <= sub_nxt;
      idx_r        <= idx_nxt;
      id_map_r     <= id_map_nxt;
    end
  end

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != jmsc_pkg::ST_OK && step && !last_byte) |=> err_r == $past(err_r))
    else $error("latched error changed");
  a_end_frame: assert property (@(posedge clk) disable iff (!rst_n)
    end_seen_r |-> (frame_seen_r && scan_seen_r))
    else $error("end seen without frame and scan");
  a_scan_frame: assert property (@(posedge clk) disable iff (!rst_n)
    scan_seen_r |-> frame_seen_r)
    else $error("scan without frame");
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(phase_r))
    else $error("phase not one-hot");

endmodule

@@ sv/jpeg_marker_structure_checker.sv @@
// ----------------------------------------------------------------------------
// jpeg_marker_structure_checker
// Checks the marker structure of a JPEG file streamed one byte per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   in_tdata carries one file byte per transaction, in_tlast marks the final
//   byte. Only the final byte produces an out_ transaction carrying status
//   and the frame header fields; other bytes produce nothing.
//   One byte is taken every cycle in_tready is high; the result is on out_
//   in the cycle after the final byte, from a single output register.
//   in_tready is low only while a result is held and out_tready is low, so
//   a stalled receiver holds the result and blocks further input.
//   After each final byte the parser returns to its start state; the
//   limit registers keep their values.
//   cfg_we/cfg_addr/cfg_wdata write the limit registers (0 record, 1
//   dimension, 2 pixel, 3 component); write them only while idle.
//   Reset clears the parser and loads the default limits.
// ----------------------------------------------------------------------------
module jpeg_marker_structure_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // byte_value
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[2:0], width[18:3], height[34:19], comp_cnt[42:35],
  // sample_precision[50:43], frame_kind[58:51], profile_ok[59], zero pad
  output logic [63:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  jmsc_pkg::cfg_t    cfg_r;
  jmsc_pkg::status_t err;
  jmsc_pkg::status_t status;
  jmsc_pkg::frame_t  frame, fout;
  logic        end_seen, frame_seen, unsup, prof;
  logic        step;
  logic        dims_bad, fmt_ok;
  logic [31:0] area;
  logic [63:0] out_tdata_r;
  logic        out_tvalid_r;

  assign in_tready = !out_tvalid_r || out_tready;
  assign step      = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.record_limit    <= jmsc_pkg::RECORD_LIMIT_RST;
      cfg_r.dimension_limit <= jmsc_pkg::DIMENSION_LIMIT_RST;
      cfg_r.pixel_limit     <= jmsc_pkg::PIXEL_LIMIT_RST;
      cfg_r.component_limit <= jmsc_pkg::COMPONENT_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        jmsc_pkg::REG_RECORD:    cfg_r.record_limit    <= cfg_wdata[15:0];
        jmsc_pkg::REG_DIMENSION: cfg_r.dimension_limit <= cfg_wdata[15:0];
        jmsc_pkg::REG_PIXEL:     cfg_r.pixel_limit     <= cfg_wdata;
        jmsc_pkg::REG_COMPONENT: cfg_r.component_limit <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  jmsc_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .byte_value   (in_tdata),
    .last_byte    (in_tlast),
    .record_limit (cfg_r.record_limit),
    .err_o        (err),
    .end_seen_o   (end_seen),
    .frame_seen_o (frame_seen),
    .unsup_o      (unsup),
    .frame_o      (frame)
  );

  // 16x16 product fits 32 bits; compare against pixel limit directly.
  assign area     = frame.width * frame.height;
  assign dims_bad = (frame.width == 16'd0) || (frame.height == 16'd0) ||
                    (frame.width > cfg_r.dimension_limit) ||
                    (frame.height > cfg_r.dimension_limit) || (area > cfg_r.pixel_limit);
  assign fmt_ok   = (frame.precision == 8'd8) &&
                    (frame.kind == jmsc_pkg::M_SOF0 || frame.kind == jmsc_pkg::M_SOF1 ||
                     frame.kind == jmsc_pkg::M_SOF2) &&
                    (frame.comps != 8'd0) && (frame.comps <= cfg_r.component_limit);

  always_comb begin
    if (err != jmsc_pkg::ST_OK) status = err;
    else if (!end_seen) status = jmsc_pkg::ST_INVALID;
    else if (dims_bad) status = jmsc_pkg::ST_DIMS;
    else if (fmt_ok) status = jmsc_pkg::ST_OK;
    else status = jmsc_pkg::ST_PROFILE;
  end

  assign fout = frame_seen ? frame : '0;
  assign prof = (status == jmsc_pkg::ST_OK || status == jmsc_pkg::ST_PROFILE) && !unsup;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (step) begin
      out_tvalid_r <= in_tlast;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_tlast) begin
      out_tdata_r <= {4'd0, prof, fout.kind, fout.precision, fout.comps,
                      fout.height, fout.width, status};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result dropped under stall");
  a_block: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input taken while result stalled");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[2:0] <= 3'd4))
    else $error("status code out of range");

endmodule
